/* rtl/referee_frame_receiver_crc16_assert.svh */
// Assertion macros shared by the receiver RTL.
`ifndef REFEREE_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define REFEREE_FRAME_RECEIVER_CRC16_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define RFR_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define RFR_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/rfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rfr_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 25;
   localparam int PAYLOAD_OFFSET      = 7;
   localparam int FRAME_OVERHEAD      = 9;
   localparam int MIN_HEADER_BYTES    = 7;
   localparam logic [7:0]  SOF_BYTE   = 8'hA5;
   localparam logic [15:0] CRC_SEED   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h8408;

   // Lookup result: hit flag and dense command code.
   typedef struct packed {
      logic       hit;
      logic [3:0] code;
   } cmd_lookup_type;

   // Map a command id to its dense code.
   function automatic cmd_lookup_type cmd_lookup(input logic [15:0] id);
      cmd_lookup_type r;
      r.hit  = 1'b1;
      r.code = 4'd0;
      unique case (id)
         16'h0001: r.code = 4'd0;
         16'h0002: r.code = 4'd1;
         16'h0003: r.code = 4'd2;
         16'h0101: r.code = 4'd3;
         16'h0102: r.code = 4'd4;
         16'h0103: r.code = 4'd5;
         16'h0201: r.code = 4'd6;
         16'h0202: r.code = 4'd7;
         16'h0203: r.code = 4'd8;
         16'h0204: r.code = 4'd9;
         16'h0205: r.code = 4'd10;
         16'h0206: r.code = 4'd11;
         16'h0207: r.code = 4'd12;
         default:  r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   // Payload size in bytes for each dense code.
   function automatic logic [4:0] payload_size(input logic [3:0] code);
      logic [4:0] s;
      unique case (code)
         4'd0:    s = 5'd3;
         4'd1:    s = 5'd1;
         4'd2:    s = 5'd2;
         4'd3:    s = 5'd4;
         4'd4:    s = 5'd4;
         4'd5:    s = 5'd3;
         4'd6:    s = 5'd15;
         4'd7:    s = 5'd14;
         4'd8:    s = 5'd16;
         4'd9:    s = 5'd1;
         4'd10:   s = 5'd3;
         4'd11:   s = 5'd1;
         4'd12:   s = 5'd6;
         default: s = 5'd1;
      endcase
      return s;
   endfunction

   // One byte of the reflected CRC-16, eight bit steps.
   function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/rfr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Received byte channel.
interface rfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       chunk_last;
   modport source (output valid, output rx_byte, output chunk_last, input ready);
   modport sink   (input valid, input rx_byte, input chunk_last, output ready);
endinterface

// Payload byte result channel.
interface rfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] cmd_code;
   logic [7:0] payload_byte;
   logic [3:0] byte_index;
   logic       last_of_frame;
   modport source (output valid, output cmd_code, output payload_byte, output byte_index,
                   output last_of_frame, input ready);
   modport sink   (input valid, input cmd_code, input payload_byte, input byte_index,
                   input last_of_frame, output ready);
endinterface
`default_nettype wire

/* rtl/referee_frame_receiver_crc16.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Contents
// req_chan  in         rx_byte, chunk_last
// rsp_chan  out        cmd_code, payload_byte, byte_index, last_of_frame
//
// A byte passes the append and evaluate states, and once the window holds seven bytes or more
// also the command id reads; a rescan visits the window bytes one at a time.
// A complete frame then passes the CRC pass, with one window read per byte, and the check
// byte reads before the payload stage, which emits its payload bytes in turn.
// Reset is synchronous and empties the window; the memory needs no clearing.
// A stalled result channel holds the sequencer in the payload emit state.
module referee_frame_receiver_crc16 #(
   parameter int MAX_FRAME_BYTES = rfr_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire       clock,
   input  wire       reset,
   rfr_req_if.sink   req_chan,
   rfr_rsp_if.source rsp_chan
);
   `include "referee_frame_receiver_crc16_assert.svh"

   localparam int AW = $clog2(MAX_FRAME_BYTES);
   localparam int FW = $clog2(MAX_FRAME_BYTES + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_APPEND = 4'd1;
   localparam logic [3:0] S_EVAL   = 4'd2;
   localparam logic [3:0] S_ID0    = 4'd3;
   localparam logic [3:0] S_ID1    = 4'd4;
   localparam logic [3:0] S_CRC    = 4'd5;
   localparam logic [3:0] S_CK0    = 4'd6;
   localparam logic [3:0] S_CK1    = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;
   localparam logic [3:0] S_DISC   = 4'd9;
   localparam logic [3:0] S_SCAN   = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [7:0]    byte_ff, byte_in;
   logic          final_ff, final_in;
   logic          pre_ff, pre_in;
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] k_ff, k_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    lo_ff, lo_in;
   logic          mlo_ff, mlo_in;
   logic [3:0]    code_ff, code_in;
   logic [4:0]    plen_ff, plen_in;
   logic [4:0]    len_ff, len_in;
   logic [3:0]    pi_ff, pi_in;
   logic          rv_ff, rv_in;
   logic [3:0]    rcode_ff, rcode_in;
   logic [7:0]    rbyte_ff, rbyte_in;
   logic [3:0]    ridx_ff, ridx_in;
   logic          rlast_ff, rlast_in;

   logic [FW-1:0] rd_idx;
   logic [7:0]    rd_data;
   logic          wr_en;
   logic          out_free;
   rfr_pkg::cmd_lookup_type lk;
   logic [4:0]    lk_plen;
   logic [5:0]    lk_len;

   // Logical window index to memory address, wrapping once around the ring.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [FW-1:0] i);
      logic [FW:0] s;
      s = (FW+1)'(h) + (FW+1)'(i);
      if (s >= (FW+1)'(MAX_FRAME_BYTES)) s = s - (FW+1)'(MAX_FRAME_BYTES);
      return s[AW-1:0];
   endfunction

   rfr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES)) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (phys(head_ff, fill_ff)),
      .wr_data (byte_ff),
      .rd_addr (phys(head_ff, rd_idx)),
      .rd_data (rd_data)
   );

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rv_ff;
   assign rsp_chan.cmd_code    = rcode_ff;
   assign rsp_chan.payload_byte = rbyte_ff;
   assign rsp_chan.byte_index  = ridx_ff;
   assign rsp_chan.last_of_frame = rlast_ff;

   assign out_free = !rv_ff || rsp_chan.ready;
   assign lk       = rfr_pkg::cmd_lookup({rd_data, lo_ff});
   assign lk_plen  = rfr_pkg::payload_size(lk.code);
   assign lk_len   = 6'(lk_plen) + 6'(rfr_pkg::FRAME_OVERHEAD);

   // Sequencer: append, header decode, CRC pass, payload emit and rescans.
   always_comb begin
      state_in = state_ff;
      byte_in  = byte_ff;
      final_in = final_ff;
      pre_in   = pre_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      k_in     = k_ff;
      crc_in   = crc_ff;
      lo_in    = lo_ff;
      mlo_in   = mlo_ff;
      code_in  = code_ff;
      plen_in  = plen_ff;
      len_in   = len_ff;
      pi_in    = pi_ff;
      rv_in    = rv_ff && !rsp_chan.ready;
      rcode_in = rcode_ff;
      rbyte_in = rbyte_ff;
      ridx_in  = ridx_ff;
      rlast_in = rlast_ff;
      rd_idx   = '0;
      wr_en    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               byte_in  = req_chan.rx_byte;
               final_in = req_chan.chunk_last;
               if (32'(fill_ff) >= MAX_FRAME_BYTES) begin
                  pre_in   = 1'b1;
                  k_in     = FW'(1);
                  state_in = S_DISC;
               end else begin
                  state_in = S_APPEND;
               end
            end
         end
         S_APPEND: begin
            if (fill_ff != '0 || byte_ff == rfr_pkg::SOF_BYTE) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + FW'(1);
            end
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (fill_ff == '0) begin
               state_in = S_IDLE;
            end else if (32'(fill_ff) < rfr_pkg::MIN_HEADER_BYTES) begin
               if (final_ff) begin
                  k_in     = FW'(1);
                  state_in = S_DISC;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               rd_idx   = FW'(5);
               state_in = S_ID0;
            end
         end
         S_ID0: begin
            lo_in    = rd_data;
            rd_idx   = FW'(6);
            state_in = S_ID1;
         end
         S_ID1: begin
            code_in = lk.code;
            plen_in = lk_plen;
            len_in  = lk_len[4:0];
            if (!lk.hit || 32'(lk_len) > MAX_FRAME_BYTES) begin
               k_in     = FW'(1);
               state_in = S_DISC;
            end else if (32'(fill_ff) < 32'(lk_len)) begin
               if (final_ff) begin
                  k_in     = FW'(1);
                  state_in = S_DISC;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               crc_in   = rfr_pkg::CRC_SEED;
               k_in     = '0;
               rd_idx   = '0;
               state_in = S_CRC;
            end
         end
         S_CRC: begin
            crc_in = rfr_pkg::crc16_byte(crc_ff, rd_data);
            if (32'(k_ff) + 1 < 32'(len_ff) - 2) begin
               k_in   = k_ff + FW'(1);
               rd_idx = k_ff + FW'(1);
            end else begin
               rd_idx   = FW'(len_ff - 5'd2);
               state_in = S_CK0;
            end
         end
         S_CK0: begin
            mlo_in   = (rd_data == crc_ff[7:0]);
            rd_idx   = FW'(len_ff - 5'd1);
            state_in = S_CK1;
         end
         S_CK1: begin
            if (mlo_ff && rd_data == crc_ff[15:8]) begin
               pi_in    = '0;
               rd_idx   = FW'(rfr_pkg::PAYLOAD_OFFSET);
               state_in = S_EMIT;
            end else begin
               k_in     = FW'(1);
               state_in = S_DISC;
            end
         end
         S_EMIT: begin
            rd_idx = FW'(rfr_pkg::PAYLOAD_OFFSET) + FW'(pi_ff);
            if (out_free) begin
               rv_in    = 1'b1;
               rcode_in = code_ff;
               rbyte_in = rd_data;
               ridx_in  = pi_ff;
               rlast_in = (5'(pi_ff) + 5'd1 == plen_ff);
               if (5'(pi_ff) + 5'd1 == plen_ff) begin
                  k_in     = FW'(len_ff);
                  state_in = S_DISC;
               end else begin
                  pi_in  = pi_ff + 4'd1;
                  rd_idx = FW'(rfr_pkg::PAYLOAD_OFFSET) + FW'(pi_ff) + FW'(1);
               end
            end
         end
         S_DISC: begin
            if (k_ff >= fill_ff) begin
               fill_in  = '0;
               pre_in   = 1'b0;
               state_in = pre_ff ? S_APPEND : S_EVAL;
            end else begin
               rd_idx   = k_ff;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_data == rfr_pkg::SOF_BYTE) begin
               head_in  = phys(head_ff, k_ff);
               fill_in  = fill_ff - k_ff;
               pre_in   = 1'b0;
               state_in = pre_ff ? S_APPEND : S_EVAL;
            end else if (k_ff + FW'(1) >= fill_ff) begin
               fill_in  = '0;
               pre_in   = 1'b0;
               state_in = pre_ff ? S_APPEND : S_EVAL;
            end else begin
               k_in   = k_ff + FW'(1);
               rd_idx = k_ff + FW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state is cleared by reset; the data registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         final_ff <= 1'b0;
         pre_ff   <= 1'b0;
         head_ff  <= '0;
         fill_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
         pre_ff   <= pre_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         rv_ff    <= rv_in;
      end
      byte_ff  <= byte_in;
      k_ff     <= k_in;
      crc_ff   <= crc_in;
      lo_ff    <= lo_in;
      mlo_ff   <= mlo_in;
      code_ff  <= code_in;
      plen_ff  <= plen_in;
      len_ff   <= len_in;
      pi_ff    <= pi_in;
      rcode_ff <= rcode_in;
      rbyte_ff <= rbyte_in;
      ridx_ff  <= ridx_in;
      rlast_ff <= rlast_in;
   end

   // The window never holds more bytes than the ring has entries.
   `RFR_CHECK(a_fill_bound, 32'(fill_ff) <= MAX_FRAME_BYTES, "window fill above capacity")
   // The ring head always addresses a real entry.
   `RFR_CHECK(a_head_bound, 32'(head_ff) < MAX_FRAME_BYTES, "window head out of range")
   // After the last byte of a chunk is fully processed the window is empty.
   `RFR_IMPLIES(a_chunk_empty, state_ff == S_IDLE && final_ff, fill_ff == '0, "chunk end left bytes")
   // Payload emission stays inside the frame payload.
   `RFR_IMPLIES(a_emit_range, state_ff == S_EMIT, 5'(pi_ff) < plen_ff, "payload index too large")
endmodule
`default_nettype wire

/* rtl/rfr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// Single write port, single registered read port memory.
module rfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* sim/frame_payload_checker.sv */
`timescale 1ns / 1ps
module frame_payload_checker (
   input  wire      clock,
   input  wire      reset,
   rfr_req_if       req_chan,
   rfr_rsp_if       rsp_chan,
   output int       fail_count,
   output int       pending_count
);

   localparam int WINDOW_BYTES = rfr_pkg::MAX_FRAME_BYTES_DEF;

   typedef struct packed {
      logic [3:0] cmd_code;
      logic [7:0] payload_byte;
      logic [3:0] byte_index;
      logic       last_of_frame;
   } payload_beat_type;

   payload_beat_type expected_beats[$];
   logic [7:0]    window_bytes[WINDOW_BYTES];
   int            window_count;

   // Dense code of a command id, or -1 when the id is not known.
   function automatic int id_to_code(input logic [15:0] id);
      case (id)
         16'h0001: return 0;
         16'h0002: return 1;
         16'h0003: return 2;
         16'h0101: return 3;
         16'h0102: return 4;
         16'h0103: return 5;
         16'h0201: return 6;
         16'h0202: return 7;
         16'h0203: return 8;
         16'h0204: return 9;
         16'h0205: return 10;
         16'h0206: return 11;
         16'h0207: return 12;
         default:  return -1;
      endcase
   endfunction

   function automatic int code_to_payload_len(input int code);
      int sizes[13] = '{3, 1, 2, 4, 4, 3, 15, 14, 16, 1, 3, 1, 6};
      return sizes[code];
   endfunction

   // Drop the first count bytes, then drop bytes until a start byte leads.
   task automatic drop_front(input int count);
      int k;
      if (count > window_count) count = window_count;
      for (k = count; k < window_count; k++)
         if (window_bytes[k] == rfr_pkg::SOF_BYTE) break;
      if (k >= window_count) begin
         window_count = 0;
         return;
      end
      for (int j = 0; j < window_count - k; j++) window_bytes[j] = window_bytes[j + k];
      window_count -= k;
   endtask

   function automatic logic [15:0] window_crc(input int len);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < len; i++) begin
         c ^= {8'h00, window_bytes[i]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      return c;
   endfunction

   // Append the byte to the window, then scan it for complete frames and queue their payload bytes.
   task automatic predict_byte(input logic [7:0] rx, input logic chunk_end);
      int code;
      int plen;
      int len;
      logic [15:0] crc;
      payload_beat_type beat;
      if (window_count >= WINDOW_BYTES) drop_front(1);
      if (window_count > 0 || rx == rfr_pkg::SOF_BYTE) begin
         window_bytes[window_count] = rx;
         window_count++;
      end
      while (window_count > 0) begin
         if (window_count < 7) begin
            if (chunk_end) begin
               drop_front(1);
               continue;
            end
            break;
         end
         code = id_to_code({window_bytes[6], window_bytes[5]});
         if (code < 0) begin
            drop_front(1);
            continue;
         end
         plen = code_to_payload_len(code);
         len = plen + 9;
         if (len > WINDOW_BYTES) begin
            drop_front(1);
            continue;
         end
         if (window_count < len) begin
            if (chunk_end) begin
               drop_front(1);
               continue;
            end
            break;
         end
         crc = window_crc(len - 2);
         if (crc[7:0] == window_bytes[len - 2] && crc[15:8] == window_bytes[len - 1]) begin
            for (int i = 0; i < plen; i++) begin
               beat.cmd_code      = code[3:0];
               beat.payload_byte  = window_bytes[7 + i];
               beat.byte_index    = i[3:0];
               beat.last_of_frame = (i + 1 == plen);
               expected_beats.push_back(beat);
            end
            drop_front(len);
         end else begin
            drop_front(1);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input payload_beat_type got,
                                  input payload_beat_type want);
      $display("mismatch %s: got code=%0d byte=%02h idx=%0d last=%0d, %s",
               what, got.cmd_code, got.payload_byte, got.byte_index, got.last_of_frame,
               $sformatf("want code=%0d byte=%02h idx=%0d last=%0d", want.cmd_code,
                         want.payload_byte, want.byte_index, want.last_of_frame));
      fail_count++;
   endtask

   // Predict on each accepted byte and compare each accepted payload transaction.
   always @(posedge clock) begin
      payload_beat_type got;
      payload_beat_type want;
      if (reset) begin
         window_count = 0;
         fail_count   = 0;
         expected_beats.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.cmd_code, rsp_chan.payload_byte, rsp_chan.byte_index,
                   rsp_chan.last_of_frame};
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected", got, '0);
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) report_mismatch("field", got, want);
            end
         end
         if (req_chan.valid && req_chan.ready)
            predict_byte(req_chan.rx_byte, req_chan.chunk_last);
      end
      pending_count = expected_beats.size();
   end
endmodule

/* sim/tb_referee_frame_receiver_crc16.sv */
`timescale 1ns / 1ps
module tb_referee_frame_receiver_crc16;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   bit   idle_allowed;
   bit   hold_rsp;

   rfr_req_if req_chan ();
   rfr_rsp_if rsp_chan ();

   referee_frame_receiver_crc16 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   frame_payload_checker payload_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   logic [7:0] frame_buf[32];
   int         frame_len;
   logic [15:0] known_ids[13] = '{16'h0001, 16'h0002, 16'h0003, 16'h0101, 16'h0102,
      16'h0103, 16'h0201, 16'h0202, 16'h0203, 16'h0204, 16'h0205, 16'h0206, 16'h0207};
   int payload_lens[13] = '{3, 1, 2, 4, 4, 3, 15, 14, 16, 1, 3, 1, 6};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on total cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver side: random stall bursts, with one long hold when requested.
   initial begin
      int burst;
      bit hold_done;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            for (int i = 0; i < 300; i++) @(posedge clock);
            hold_done = 1'b1;
         end else if (idle_allowed && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_chan.ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one byte and wait until it is accepted, with optional idle burst first.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_allowed && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.rx_byte    <= b;
      req_chan.chunk_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Build a frame for id index k into frame_buf, optionally corrupting the CRC.
   task automatic build_frame(input int k, input bit bad_crc);
      logic [15:0] c;
      frame_len = payload_lens[k] + 9;
      frame_buf[0] = rfr_pkg::SOF_BYTE;
      for (int i = 1; i < frame_len; i++) frame_buf[i] = 8'($urandom_range(0, 255));
      frame_buf[5] = known_ids[k][7:0];
      frame_buf[6] = known_ids[k][15:8];
      c = 16'hFFFF;
      for (int i = 0; i < frame_len - 2; i++) begin
         c ^= {8'h00, frame_buf[i]};
         for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      frame_buf[frame_len - 2] = c[7:0];
      frame_buf[frame_len - 1] = c[15:8] ^ (bad_crc ? 8'h01 : 8'h00);
   endtask

   task automatic send_frame(input bit end_chunk);
      for (int i = 0; i < frame_len; i++)
         send_byte(frame_buf[i], end_chunk && (i == frame_len - 1));
   endtask

   // Stimulus.
   initial begin
      int sent;
      int pick;
      int cut;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.rx_byte    = 8'h00;
      req_chan.chunk_last = 1'b0;
      idle_allowed        = 1'b0;
      hold_rsp            = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: noise bytes, each id once, a CRC failure, a truncated frame.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      for (int k = 0; k < 13; k++) begin
         build_frame(k, 1'b0);
         send_frame(k == 12);
      end
      build_frame(0, 1'b1);
      send_frame(1'b0);
      build_frame(6, 1'b0);
      for (int i = 0; i < 10; i++) send_byte(frame_buf[i], i == 9);
      // A stray start byte right before a good frame, so the header is first read one byte early.
      send_byte(rfr_pkg::SOF_BYTE, 1'b0);
      build_frame(1, 1'b0);
      send_frame(1'b1);

      // Long receiver hold while frames keep coming.
      idle_allowed = 1'b1;
      hold_rsp = 1'b1;
      for (int n = 0; n < 2; n++) begin
         build_frame(8, 1'b0);
         send_frame(1'b0);
      end
      // Sender pause until everything has drained.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      // Random part: mostly well-formed frames, some broken, some noise.
      sent = 0;
      while (sent < 95) begin
         if (sent > 70) idle_allowed = 1'b0;
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            build_frame($urandom_range(0, 12), 1'b0);
            send_frame($urandom_range(0, 3) == 0);
            sent += frame_len;
         end else if (pick < 8) begin
            build_frame($urandom_range(0, 12), 1'b1);
            cut = $urandom_range(1, frame_len);
            for (int i = 0; i < cut; i++) send_byte(frame_buf[i], $urandom_range(0, 7) == 0);
            sent += cut;
         end else begin
            send_byte($urandom_range(0, 1) ? rfr_pkg::SOF_BYTE : 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            sent++;
         end
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
